@@ rtl/s256sb_pkg.sv @@
// s256sb_pkg: shared types, round constants and round functions for the
// single-block sha-256 pipeline; no dependencies
package s256sb_pkg;

  localparam int NumRounds = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [63:0] msg_bytes_0_7;
    logic [63:0] msg_bytes_8_15;
    logic [63:0] msg_bytes_16_23;
    logic [63:0] msg_bytes_24_31;
    logic        last_slot;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_bytes_0_7;
    logic [63:0] digest_bytes_8_15;
    logic [63:0] digest_bytes_16_23;
    logic [63:0] digest_bytes_24_31;
    logic        last_digest;
  } out_item_t;

  // working variables a..h
  typedef struct packed {
    word_t a, b, c, d, e, f, g, h;
  } hstate_t;

  localparam word_t PadWord  = 32'h80000000;
  localparam word_t LenWord  = 32'd256;

  localparam hstate_t InitHash = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t v);
    ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t ssig1(input word_t v);
    ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic word_t bsig0(input word_t v);
    bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t bsig1(input word_t v);
    bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

endpackage

@@ rtl/s256sb_if.sv @@
// s256sb_if: valid/ready channel carrying one payload item
// depends on s256sb_pkg
interface s256sb_in_if;
  logic                 valid;
  logic                 ready;
  s256sb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface s256sb_out_if;
  logic                  valid;
  logic                  ready;
  s256sb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/s256sb_round.sv @@
// s256sb_round: one compression round with its message schedule window,
// registered; depends on s256sb_pkg
module s256sb_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                vld_in,
  input  s256sb_pkg::word_t   k_in,
  input  s256sb_pkg::hstate_t st_in,
  input  s256sb_pkg::word_t   w_in [16],
  input  logic                last_in,
  output logic                vld_r,
  output s256sb_pkg::hstate_t st_r,
  output s256sb_pkg::word_t   w_r [16],
  output logic                last_r
);
  import s256sb_pkg::*;

  word_t   t1, t2, wnew;
  hstate_t st_nxt;

  always_comb begin
    t1 = st_in.h + bsig1(st_in.e) + ((st_in.e & st_in.f) ^ (~st_in.e & st_in.g))
         + k_in + w_in[0];
    t2 = bsig0(st_in.a) + ((st_in.a & st_in.b) ^ (st_in.a & st_in.c)
         ^ (st_in.b & st_in.c));
    st_nxt = '{t1 + t2, st_in.a, st_in.b, st_in.c, st_in.d + t1,
               st_in.e, st_in.f, st_in.g};
    // next schedule word w[t+16]
    wnew = ssig1(w_in[14]) + w_in[9] + ssig0(w_in[1]) + w_in[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r   <= st_nxt;
      last_r <= last_in;
      for (int i = 0; i < 15; i++) w_r[i] <= w_in[i+1];
      w_r[15] <= wnew;
    end
  end
endmodule

@@ rtl/s256sb_final.sv @@
// s256sb_final: adds initial hash back in and holds the result register
// depends on s256sb_pkg
module s256sb_final (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                vld_in,
  input  s256sb_pkg::hstate_t st_in,
  input  logic                last_in,
  output logic                vld_r,
  output s256sb_pkg::out_item_t res_r
);
  import s256sb_pkg::*;

  out_item_t res_nxt;

  always_comb begin
    res_nxt.digest_bytes_0_7   = {st_in.a + InitHash.a, st_in.b + InitHash.b};
    res_nxt.digest_bytes_8_15  = {st_in.c + InitHash.c, st_in.d + InitHash.d};
    res_nxt.digest_bytes_16_23 = {st_in.e + InitHash.e, st_in.f + InitHash.f};
    res_nxt.digest_bytes_24_31 = {st_in.g + InitHash.g, st_in.h + InitHash.h};
    res_nxt.last_digest        = last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end
endmodule

@@ rtl/sha256_single_block_32byte_top.sv @@
// sha256_single_block_32byte_top: fully unrolled sha-256 of a 32-byte message
// depends on s256sb_pkg, s256sb_if, s256sb_round, s256sb_final

// One 32-byte message enters per transfer on in_ch and its digest leaves on
// out_ch, in order, with the last flag carried along. The compression is
// unrolled into 64 registered round stages plus one final-add stage, so one
// message is taken every cycle unless out_ch stalls. The whole pipeline
// advances together whenever the output register is empty or being taken;
// a stall on out_ch freezes every stage so nothing is lost or repeated.
// Reset clears only valid bits.
module sha256_single_block_32byte_top (
  input logic          clk,
  input logic          rst_n,
  s256sb_in_if.sink    in_ch,
  s256sb_out_if.source out_ch
);
  import s256sb_pkg::*;

  // per-stage state, index 0 is the pipeline input
  logic    vld  [NumRounds+1];
  hstate_t st   [NumRounds+1];
  word_t   w    [NumRounds+1][16];
  logic    last [NumRounds+1];
  logic    adv;
  logic    out_vld;

  // global advance: output register free or its transfer completes
  assign adv          = !out_vld || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = out_vld;

  // stage 0: message words plus fixed padding for a 256-bit message
  always_comb begin
    vld[0]  = in_ch.valid;
    st[0]   = InitHash;
    last[0] = in_ch.data.last_slot;
    w[0][0] = in_ch.data.msg_bytes_0_7[63:32];
    w[0][1] = in_ch.data.msg_bytes_0_7[31:0];
    w[0][2] = in_ch.data.msg_bytes_8_15[63:32];
    w[0][3] = in_ch.data.msg_bytes_8_15[31:0];
    w[0][4] = in_ch.data.msg_bytes_16_23[63:32];
    w[0][5] = in_ch.data.msg_bytes_16_23[31:0];
    w[0][6] = in_ch.data.msg_bytes_24_31[63:32];
    w[0][7] = in_ch.data.msg_bytes_24_31[31:0];
    w[0][8] = PadWord;
    for (int i = 9; i < 15; i++) w[0][i] = '0;
    w[0][15] = LenWord;
  end

  // one round per stage
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    s256sb_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_in  (vld[r]),
      .k_in    (RoundK[r]),
      .st_in   (st[r]),
      .w_in    (w[r]),
      .last_in (last[r]),
      .vld_r   (vld[r+1]),
      .st_r    (st[r+1]),
      .w_r     (w[r+1]),
      .last_r  (last[r+1])
    );
  end

  // final add and output register
  s256sb_final u_final (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_in  (vld[NumRounds]),
    .st_in   (st[NumRounds]),
    .last_in (last[NumRounds]),
    .vld_r   (out_vld),
    .res_r   (out_ch.data)
  );
endmodule

@@ tb/sv/sha256_single_block_32byte_top_tb.sv @@
// sha256_single_block_32byte_top_tb: drives 32-byte messages into the hash pipeline and
// checks each digest against a sha-256 predictor; depends on s256sb_pkg, s256sb_if and the top
module sha256_single_block_32byte_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s256sb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  s256sb_in_if  in_ch ();
  s256sb_out_if out_ch ();

  sha256_single_block_32byte_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // round constants and initial hash values, kept local to the predictor
  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam int PipeLatency = 65;

  in_item_t  msg_queue [$];     // messages waiting for the driver
  out_item_t digest_queue [$];  // predicted digests, oldest first
  int        fail_count = 0;
  bit        in_taken = 1'b0;     // input transfer seen at the last rising edge
  bit        hold_sender = 1'b0;  // sender pause until pipeline drains
  int        long_stall = 0;      // receiver hold-off cycles left
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_phase = 0;

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // sha-256 of one 32-byte message with its fixed padding block
  function automatic out_item_t hash_msg(in_item_t m);
    logic [31:0] w [64];
    logic [31:0] s [8];
    logic [63:0] words [4];
    logic [31:0] t1, t2, sg0, sg1;
    out_item_t   r;
    words = '{m.msg_bytes_0_7, m.msg_bytes_8_15, m.msg_bytes_16_23, m.msg_bytes_24_31};
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = words[i][63:32];
      w[2*i+1] = words[i][31:0];
    end
    w[8] = 32'h80000000;
    for (int i = 9; i < 15; i++) w[i] = '0;
    w[15] = 32'd256;
    for (int i = 16; i < 64; i++) begin
      sg0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      sg1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = sg1 + w[i-7] + sg0 + w[i-16];
    end
    s = HInit;
    for (int i = 0; i < 64; i++) begin
      t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + KTab[i] + w[i];
      t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
      s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) s[i] = s[i] + HInit[i];
    r.digest_bytes_0_7   = {s[0], s[1]};
    r.digest_bytes_8_15  = {s[2], s[3]};
    r.digest_bytes_16_23 = {s[4], s[5]};
    r.digest_bytes_24_31 = {s[6], s[7]};
    r.last_digest        = m.last_slot;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t rand_msg();
    in_item_t m;
    m.msg_bytes_0_7   = rand64();
    m.msg_bytes_8_15  = rand64();
    m.msg_bytes_16_23 = rand64();
    m.msg_bytes_24_31 = rand64();
    m.last_slot       = ($urandom_range(0, 7) == 0);
    return m;
  endfunction

  // driver: bursts and gaps, changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the offered item until the transfer happens
    end else begin
      if (gap_left > 0) gap_left = gap_left - 1;
      if (!hold_sender && gap_left == 0 && msg_queue.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= msg_queue.pop_front();
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // prediction on each accepted input transfer
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) digest_queue.push_back(hash_msg(in_ch.data));
  end

  // receiver stall pattern: long hold-off, then periodic plus random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall = long_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 97;
      if (stall_phase < 40) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 5 != 0);
    end
  end

  // monitor: compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: digest with none expected: got %h", $time, out_ch.data);
        fail_count = fail_count + 1;
      end else begin
        want = digest_queue.pop_front();
        if (out_ch.data.digest_bytes_0_7 !== want.digest_bytes_0_7) begin
          $display("%0t: digest_bytes_0_7 expected %h got %h", $time,
                   want.digest_bytes_0_7, out_ch.data.digest_bytes_0_7);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.digest_bytes_8_15 !== want.digest_bytes_8_15) begin
          $display("%0t: digest_bytes_8_15 expected %h got %h", $time,
                   want.digest_bytes_8_15, out_ch.data.digest_bytes_8_15);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.digest_bytes_16_23 !== want.digest_bytes_16_23) begin
          $display("%0t: digest_bytes_16_23 expected %h got %h", $time,
                   want.digest_bytes_16_23, out_ch.data.digest_bytes_16_23);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.digest_bytes_24_31 !== want.digest_bytes_24_31) begin
          $display("%0t: digest_bytes_24_31 expected %h got %h", $time,
                   want.digest_bytes_24_31, out_ch.data.digest_bytes_24_31);
          fail_count = fail_count + 1;
        end
        if (out_ch.data.last_digest !== want.last_digest) begin
          $display("%0t: last_digest expected %b got %b", $time,
                   want.last_digest, out_ch.data.last_digest);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    in_item_t m;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: all zeros, all ones, alternating-bit and sparse patterns, last flag both ways
    msg_queue.push_back('0);
    msg_queue.push_back('1);
    m = '0; m.last_slot = 1'b1; msg_queue.push_back(m);
    m = '1; m.last_slot = 1'b0; msg_queue.push_back(m);
    m = {{4{64'haaaaaaaaaaaaaaaa}}, 1'b0}; msg_queue.push_back(m);
    m = {{4{64'h5555555555555555}}, 1'b1}; msg_queue.push_back(m);
    m = {64'h8000000000000000, 64'h0, 64'h0, 64'h1, 1'b0}; msg_queue.push_back(m);
    m = {64'h0123456789abcdef, 64'hfedcba9876543210, 64'hffffffff00000000,
         64'h00000000ffffffff, 1'b1};
    msg_queue.push_back(m);
    for (int i = 0; i < 12; i++) msg_queue.push_back(rand_msg());
    wait (msg_queue.size() == 0);
    // sender pause until every digest is back
    hold_sender = 1'b1;
    wait (digest_queue.size() == 0 && !in_ch.valid);
    @(negedge clk);
    hold_sender = 1'b0;
    // long receiver hold-off while the sender keeps offering transfers
    for (int i = 0; i < 150; i++) msg_queue.push_back(rand_msg());
    @(negedge clk);
    long_stall = 200;
    wait (msg_queue.size() == 0);
    for (int i = 0; i < 580; i++) msg_queue.push_back(rand_msg());
    // every item offered and taken, then every digest back
    wait (msg_queue.size() == 0 && !in_ch.valid);
    wait (digest_queue.size() == 0);
    repeat (PipeLatency + 10) @(posedge clk);
    if (fail_count == 0 && digest_queue.size() == 0)
      $display("sha256_single_block_32byte_top: match");
    else $display("sha256_single_block_32byte_top: mismatch");
    $finish;
  end

  initial begin
    #2ms;
    $display("sha256_single_block_32byte_top: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/s256sb_pkg.sv
rtl/s256sb_if.sv
rtl/s256sb_round.sv
rtl/s256sb_final.sv
rtl/sha256_single_block_32byte_top.sv
tb/sv/sha256_single_block_32byte_top_tb.sv
